### src/slpt_pkg.sv
// Shared types, constants and a helper function for the lookahead-pair trainer.
// Used by slpt_frz and syscall_lookahead_pair_trainer_core; no dependencies.
`default_nettype none

package slpt_pkg;

  // Widths of the counters, registers and table flags.
  localparam int CNT_W     = 32;
  localparam int NF_W      = 10;
  localparam int WLEN_W    = 4;
  localparam int CALL_IN_W = 8;
  localparam int FLAG_W    = 8;
  localparam int BIT_W     = 3;
  localparam int MISS_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;
  localparam int PROD_W    = CNT_W + NF_W;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [NF_W-1:0]   nf_t;
  typedef logic [FLAG_W-1:0] flag_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MONITOR_ENABLE = 2'd2;

  // Reset values.
  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 4'd9;
  localparam logic [WLEN_W-1:0] NEWEST_RESET        = 4'd8;
  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_MIN   = 4'd2;
  localparam nf_t               NORMAL_FACTOR_RESET = 10'd128;
  localparam int                EMPTY_CALL          = 255;

  // Status of the freeze-test unit, returned to the sequencer.
  typedef struct packed {
    logic done;
    logic freeze;
  } frz_status_t;

  // Counter increment that sticks at the all-ones value.
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

endpackage

`default_nettype wire

### src/slpt_table.sv
// Pair-flag table: one read port with registered data and one write port.
// A clearing sweep after reset zeroes every entry. Uses no package items.
`default_nettype none

module slpt_table #(
  parameter int ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]             rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  output logic                   clearing
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [7:0]        mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  // Clearing sweep: one entry per cycle from address zero up.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port, shared between the sweep and the sequencer.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### src/slpt_frz.sv
// Freeze test unit: checks stable != 0 and train*32 > stable*normal_factor over three stages.
// Depends on slpt_pkg for counter widths and the status struct.
`default_nettype none

module slpt_frz (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire slpt_pkg::cnt_t     train,
  input  wire slpt_pkg::cnt_t     since,
  input  wire slpt_pkg::nf_t      nf,
  output slpt_pkg::frz_status_t   st
);

  logic                          v1;
  logic                          v2;
  logic                          done_q;
  logic                          freeze_q;
  slpt_pkg::cnt_t                stable;
  logic                          stable_nz;
  logic [slpt_pkg::PROD_W-1:0]   prod;
  logic [slpt_pkg::PROD_W-1:0]   scaled;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1     <= go;
      v2     <= v1;
      done_q <= v2;
    end
  end

  // Train count times 32, widened to the product width.
  assign scaled = {{(slpt_pkg::PROD_W - slpt_pkg::CNT_W - 5){1'b0}}, train, 5'b0};

  // Stable count, then product, then compare.
  always_ff @(posedge clk) begin
    stable    <= (since > train) ? '0 : train - since;
    prod      <= slpt_pkg::PROD_W'(stable) * slpt_pkg::PROD_W'(nf);
    stable_nz <= (stable != '0);
    freeze_q  <= stable_nz && (scaled > prod);
  end

  // Status back to the sequencer.
  assign st = '{done: done_q, freeze: freeze_q};

endmodule

`default_nettype wire

### src/syscall_lookahead_pair_trainer_core.sv
// Top level of the lookahead-pair trainer: sequencer, window and counters.
// Depends on slpt_pkg, slpt_table and slpt_frz.
//
//   Channel  Handshake               Payload
//   input    start, busy             call_number
//   result   done (one-cycle strobe) missing_pairs, table_updated, frozen_flag,
//                                    froze_now, unfroze_now, ignored
//   config   cfg_valid, cfg_ready    cfg_index, cfg_data
//
// An enabled call reduces the call number modulo NUM_CALLS (no subtraction
// when NUM_CALLS is 256), reads the table once per earlier window entry,
// then rewrites the pair flags when any pair is missing, or else runs the
// freeze test, skipped when the profile is already frozen; table reads go
// through the single read port and writes through the single write port.
// A disabled call gives its result in the next cycle.
// After reset the table's 4**ceil(log2(NUM_CALLS)) entries (65536 by default)
// are swept clear with busy high; configuration writes are taken meanwhile.
// Results cannot be stalled: done marks each for exactly one cycle.
`default_nettype none

module syscall_lookahead_pair_trainer_core #(
  parameter int NUM_CALLS  = 256,
  parameter int MAX_WINDOW = 9
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  call_number,
  output logic             done,
  output logic [3:0]       missing_pairs,
  output logic             table_updated,
  output logic             frozen_flag,
  output logic             froze_now,
  output logic             unfroze_now,
  output logic             ignored,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam int CALL_W = $clog2(NUM_CALLS);
  localparam int ADDR_W = 2 * CALL_W;
  localparam int WI_W   = $clog2(MAX_WINDOW);
  localparam logic [slpt_pkg::WLEN_W-1:0] LEN_MAX   = slpt_pkg::WLEN_W'(MAX_WINDOW);
  localparam logic [CALL_W-1:0]           EMPTY_RED =
    CALL_W'(slpt_pkg::EMPTY_CALL % NUM_CALLS);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_REDUCE   = 4'd1;
  localparam logic [3:0] ST_SCAN     = 4'd2;
  localparam logic [3:0] ST_SCAN_END = 4'd3;
  localparam logic [3:0] ST_DECIDE   = 4'd4;
  localparam logic [3:0] ST_UPD_RD   = 4'd5;
  localparam logic [3:0] ST_UPD_WR   = 4'd6;
  localparam logic [3:0] ST_FRZ_GO   = 4'd7;
  localparam logic [3:0] ST_FRZ_WAIT = 4'd8;

  // Configuration registers.
  logic [slpt_pkg::WLEN_W-1:0] window_length;
  slpt_pkg::nf_t               normal_factor;
  logic                        monitor_enable;

  // Trainer state.
  logic [3:0]                  state;
  logic [7:0]                  cur_raw;
  logic [slpt_pkg::WLEN_W-1:0] newest_position;
  logic [CALL_W-1:0]           call_window [MAX_WINDOW];
  logic [WI_W-1:0]             ptr;
  logic [slpt_pkg::WLEN_W-1:0] step;
  logic [slpt_pkg::MISS_W-1:0] missing;
  logic                        chk_valid;
  logic [slpt_pkg::BIT_W-1:0]  chk_bit;
  logic [ADDR_W-1:0]           upd_addr;
  logic [slpt_pkg::BIT_W-1:0]  upd_bit;
  logic                        unfroze_pend;
  slpt_pkg::cnt_t              trained_calls;
  slpt_pkg::cnt_t              since_change_count;
  logic                        frozen;

  // Table and freeze unit connections.
  logic [ADDR_W-1:0]           rd_addr;
  logic [7:0]                  rd_data;
  logic                        wr_en;
  logic [7:0]                  wr_data;
  logic                        clearing;
  logic                        frz_go;
  slpt_pkg::frz_status_t       frz_st;

  // Derived window quantities.
  logic [slpt_pkg::WLEN_W-1:0] eff_len;
  logic [slpt_pkg::WLEN_W-1:0] len_last;
  logic [WI_W-1:0]             len_m1;
  logic [WI_W-1:0]             ptr_prev;
  logic [WI_W-1:0]             newest_prev;
  logic [slpt_pkg::WLEN_W:0]   pos_inc;
  logic [slpt_pkg::WLEN_W-1:0] pos_next;
  logic                        accept;

  // Clamp the window length into the legal range.
  always_comb begin
    if (window_length < slpt_pkg::WINDOW_LENGTH_MIN) begin
      eff_len = slpt_pkg::WINDOW_LENGTH_MIN;
    end else if (window_length > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = window_length;
    end
  end

  assign len_last    = eff_len - slpt_pkg::WLEN_W'(1);
  assign len_m1      = WI_W'(len_last);
  assign ptr_prev    = (ptr == '0) ? len_m1 : ptr - WI_W'(1);
  assign newest_prev = (newest_position == '0) ? len_m1
                                               : WI_W'(newest_position - 4'd1);

  // Next write position; wraps to zero at or past the window length.
  assign pos_inc  = {1'b0, newest_position} + 5'd1;
  assign pos_next = (pos_inc >= {1'b0, eff_len}) ? '0 : pos_inc[slpt_pkg::WLEN_W-1:0];

  assign accept    = start && !busy;
  assign busy      = clearing || (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Table address of the current call against the window entry at ptr.
  assign rd_addr = {cur_raw[CALL_W-1:0], call_window[ptr]};
  assign wr_en   = (state == ST_UPD_WR);
  assign wr_data = rd_data | (8'd1 << upd_bit);
  assign frz_go  = (state == ST_FRZ_GO);

  slpt_table #(
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (upd_addr),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  slpt_frz u_frz (
    .clk   (clk),
    .rst   (rst),
    .go    (frz_go),
    .train (trained_calls),
    .since (since_change_count),
    .nf    (normal_factor),
    .st    (frz_st)
  );

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= slpt_pkg::WINDOW_LENGTH_RESET;
      normal_factor  <= slpt_pkg::NORMAL_FACTOR_RESET;
      monitor_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slpt_pkg::REG_WINDOW_LENGTH:  window_length  <= cfg_data[slpt_pkg::WLEN_W-1:0];
        slpt_pkg::REG_NORMAL_FACTOR:  normal_factor  <= cfg_data[slpt_pkg::NF_W-1:0];
        slpt_pkg::REG_MONITOR_ENABLE: monitor_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Missing-pair count: checks the flag read in the previous cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      missing <= '0;
    end else if (chk_valid && !rd_data[chk_bit]) begin
      missing <= missing + slpt_pkg::MISS_W'(1);
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      newest_position    <= slpt_pkg::NEWEST_RESET;
      trained_calls      <= '0;
      since_change_count <= '0;
      frozen             <= 1'b0;
      chk_valid          <= 1'b0;
      done               <= 1'b0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
        call_window[k] <= EMPTY_RED;
      end
    end else begin
      done      <= 1'b0;
      chk_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (monitor_enable) begin
              cur_raw         <= call_number;
              newest_position <= pos_next;
              trained_calls   <= slpt_pkg::sat_inc(trained_calls);
              state           <= ST_REDUCE;
            end else begin
              // Monitoring off: report and change nothing.
              done          <= 1'b1;
              missing_pairs <= '0;
              table_updated <= 1'b0;
              frozen_flag   <= frozen;
              froze_now     <= 1'b0;
              unfroze_now   <= 1'b0;
              ignored       <= 1'b1;
            end
          end
        end

        ST_REDUCE: begin
          // Call number modulo NUM_CALLS, one subtraction per cycle.
          if ({1'b0, cur_raw} >= 9'(NUM_CALLS)) begin
            cur_raw <= cur_raw - 8'(NUM_CALLS);
          end else begin
            call_window[newest_position[WI_W-1:0]] <= cur_raw[CALL_W-1:0];
            ptr   <= newest_prev;
            step  <= slpt_pkg::WLEN_W'(1);
            state <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // One table read per cycle, newest earlier call first.
          chk_valid <= 1'b1;
          chk_bit   <= slpt_pkg::BIT_W'(step - 4'd1);
          if (step == len_last) begin
            state <= ST_SCAN_END;
          end else begin
            step <= step + slpt_pkg::WLEN_W'(1);
            ptr  <= ptr_prev;
          end
        end

        ST_SCAN_END: begin
          state <= ST_DECIDE;
        end

        ST_DECIDE: begin
          if (missing != '0) begin
            unfroze_pend       <= frozen;
            frozen             <= 1'b0;
            since_change_count <= '0;
            ptr                <= newest_prev;
            step               <= slpt_pkg::WLEN_W'(1);
            state              <= ST_UPD_RD;
          end else begin
            since_change_count <= slpt_pkg::sat_inc(since_change_count);
            if (frozen) begin
              done          <= 1'b1;
              missing_pairs <= '0;
              table_updated <= 1'b0;
              frozen_flag   <= 1'b1;
              froze_now     <= 1'b0;
              unfroze_now   <= 1'b0;
              ignored       <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              state <= ST_FRZ_GO;
            end
          end
        end

        ST_UPD_RD: begin
          upd_addr <= rd_addr;
          upd_bit  <= slpt_pkg::BIT_W'(step - 4'd1);
          state    <= ST_UPD_WR;
        end

        ST_UPD_WR: begin
          // Flag write happens this cycle; move on to the next offset.
          if (step == len_last) begin
            done          <= 1'b1;
            missing_pairs <= missing;
            table_updated <= 1'b1;
            frozen_flag   <= 1'b0;
            froze_now     <= 1'b0;
            unfroze_now   <= unfroze_pend;
            ignored       <= 1'b0;
            state         <= ST_IDLE;
          end else begin
            step  <= step + slpt_pkg::WLEN_W'(1);
            ptr   <= ptr_prev;
            state <= ST_UPD_RD;
          end
        end

        ST_FRZ_GO: begin
          state <= ST_FRZ_WAIT;
        end

        ST_FRZ_WAIT: begin
          if (frz_st.done) begin
            frozen        <= frz_st.freeze;
            done          <= 1'b1;
            missing_pairs <= '0;
            table_updated <= 1'b0;
            frozen_flag   <= frz_st.freeze;
            froze_now     <= frz_st.freeze;
            unfroze_now   <= 1'b0;
            ignored       <= 1'b0;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
